// File: src/e2q_pkg.sv
// ----------------------------------------------------------------------------
// e2q_pkg
// Shared types and constants for the Euler-to-quaternion pipeline.
// ----------------------------------------------------------------------------
package e2q_pkg;

    localparam int ANGLE_W = 16;
    localparam int QUAT_W  = 16;
    localparam int CW      = 34;   // CORDIC datapath width, Q2.30 plus growth
    localparam int ATAN_ENTRIES = 24;

    localparam logic signed [CW-1:0] FIX_K       = 34'sd652032874;
    localparam logic signed [CW-1:0] FIX_HALF_PI = 34'sd1686629713;
    localparam logic signed [CW-1:0] FIX_PI      = 34'sd3373259426;
    localparam logic signed [QUAT_W-1:0] OUT_MAX = 16'sd16384;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] roll_angle;
        logic signed [ANGLE_W-1:0] pitch_angle;
        logic signed [ANGLE_W-1:0] yaw_angle;
    } t_angles;

    typedef struct packed {
        logic signed [QUAT_W-1:0] quat_w;
        logic signed [QUAT_W-1:0] quat_x;
        logic signed [QUAT_W-1:0] quat_y;
        logic signed [QUAT_W-1:0] quat_z;
    } t_quat;

    // Arctangent of 2^-i in Q2.30, truncated.
    function automatic logic signed [CW-1:0] atan_q30(input logic [4:0] idx);
        logic signed [CW-1:0] v;
        case (idx)
            5'd0:  v = 34'sd843314856;
            5'd1:  v = 34'sd497837829;
            5'd2:  v = 34'sd263043836;
            5'd3:  v = 34'sd133525158;
            5'd4:  v = 34'sd67021686;
            5'd5:  v = 34'sd33543515;
            5'd6:  v = 34'sd16775850;
            5'd7:  v = 34'sd8388437;
            5'd8:  v = 34'sd4194282;
            5'd9:  v = 34'sd2097149;
            5'd10: v = 34'sd1048575;
            5'd11: v = 34'sd524287;
            5'd12: v = 34'sd262143;
            5'd13: v = 34'sd131071;
            5'd14: v = 34'sd65535;
            5'd15: v = 34'sd32767;
            5'd16: v = 34'sd16383;
            5'd17: v = 34'sd8191;
            5'd18: v = 34'sd4095;
            5'd19: v = 34'sd2047;
            5'd20: v = 34'sd1023;
            5'd21: v = 34'sd511;
            5'd22: v = 34'sd255;
            5'd23: v = 34'sd127;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: src/e2q_if.sv
// ----------------------------------------------------------------------------
// e2q_angle_if / e2q_quat_if
// Valid/ready channels carrying angle triples and quaternions.
// ----------------------------------------------------------------------------
interface e2q_angle_if;
    logic                valid;
    logic                ready;
    e2q_pkg::t_angles    data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface e2q_quat_if;
    logic                valid;
    logic                ready;
    e2q_pkg::t_quat      data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: src/e2q_cordic.sv
// ----------------------------------------------------------------------------
// e2q_cordic
// Pipelined rotation-mode CORDIC producing cosine and sine of a half angle.
// One register stage per iteration plus an input stage; advances on i_en.
// ----------------------------------------------------------------------------
module e2q_cordic #(
    parameter int STAGES = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic signed [e2q_pkg::ANGLE_W-1:0]   i_angle,
    output logic signed [e2q_pkg::CW-1:0]        o_cos,
    output logic signed [e2q_pkg::CW-1:0]        o_sin
);
    localparam int CW = e2q_pkg::CW;
    localparam int NS = (STAGES < e2q_pkg::ATAN_ENTRIES) ? STAGES : e2q_pkg::ATAN_ENTRIES;

    logic signed [CW-1:0] r_x [NS+1];
    logic signed [CW-1:0] r_y [NS+1];
    logic signed [CW-1:0] r_z [NS+1];
    logic                 r_neg [NS+1];

    logic signed [CW-1:0] n_z0;
    logic                 n_neg0;

    // Quadrant fold of the half angle into the CORDIC range.
    always_comb begin
        n_z0   = {{(CW-e2q_pkg::ANGLE_W-16){i_angle[e2q_pkg::ANGLE_W-1]}}, i_angle, 16'd0};
        n_neg0 = 1'b0;
        if (n_z0 > e2q_pkg::FIX_HALF_PI) begin
            n_z0   = n_z0 - e2q_pkg::FIX_PI;
            n_neg0 = 1'b1;
        end else if (n_z0 < -e2q_pkg::FIX_HALF_PI) begin
            n_z0   = n_z0 + e2q_pkg::FIX_PI;
            n_neg0 = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]   <= e2q_pkg::FIX_K;
            r_y[0]   <= '0;
            r_z[0]   <= n_z0;
            r_neg[0] <= n_neg0;
        end
    end

    // One micro-rotation per stage.
    for (genvar g = 0; g < NS; g++) begin : g_stage
        logic signed [CW-1:0] dx, dy, at;
        assign dx = r_y[g] >>> g;
        assign dy = r_x[g] >>> g;
        assign at = e2q_pkg::atan_q30(5'(g));
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_z[g][CW-1]) begin
                    r_x[g+1] <= r_x[g] - dx;
                    r_y[g+1] <= r_y[g] + dy;
                    r_z[g+1] <= r_z[g] - at;
                end else begin
                    r_x[g+1] <= r_x[g] + dx;
                    r_y[g+1] <= r_y[g] - dy;
                    r_z[g+1] <= r_z[g] + at;
                end
                r_neg[g+1] <= r_neg[g];
            end
        end
    end

    assign o_cos = r_neg[NS] ? -r_x[NS] : r_x[NS];
    assign o_sin = r_neg[NS] ? -r_y[NS] : r_y[NS];
endmodule

// File: src/e2q_combine.sv
// ----------------------------------------------------------------------------
// e2q_combine
// Triple products, sums, rounding and saturation into Q1.14 components.
// Three register stages: first products, second products, output.
// ----------------------------------------------------------------------------
module e2q_combine (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic signed [e2q_pkg::CW-1:0]   i_cr,
    input  logic signed [e2q_pkg::CW-1:0]   i_sr,
    input  logic signed [e2q_pkg::CW-1:0]   i_cp,
    input  logic signed [e2q_pkg::CW-1:0]   i_sp,
    input  logic signed [e2q_pkg::CW-1:0]   i_cy,
    input  logic signed [e2q_pkg::CW-1:0]   i_sy,
    output e2q_pkg::t_quat                  o_quat
);
    localparam int CW = e2q_pkg::CW;
    localparam int PW = 2*CW;

    // Stage A: register the pair products shifted down to Q30.
    logic signed [CW-1:0] r_cc, r_ss, r_sc, r_cs, r_cy, r_sy;
    logic signed [PW-1:0] p_cc, p_ss, p_sc, p_cs;
    assign p_cc = i_cr * i_cp;
    assign p_ss = i_sr * i_sp;
    assign p_sc = i_sr * i_cp;
    assign p_cs = i_cr * i_sp;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cc <= CW'(p_cc >>> 30);
            r_ss <= CW'(p_ss >>> 30);
            r_sc <= CW'(p_sc >>> 30);
            r_cs <= CW'(p_cs >>> 30);
            r_cy <= i_cy;
            r_sy <= i_sy;
        end
    end

    // Stage B: second products combined in Q60.
    logic signed [PW-1:0] r_w, r_x, r_y, r_z;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_w <= r_cc * r_cy + r_ss * r_sy;
            r_x <= r_sc * r_cy - r_cs * r_sy;
            r_y <= r_cs * r_cy + r_sc * r_sy;
            r_z <= r_cc * r_sy - r_ss * r_cy;
        end
    end

    function automatic logic signed [e2q_pkg::QUAT_W-1:0] to_q14(
        input logic signed [PW-1:0] v
    );
        logic signed [PW-1:0] r;
        r = (v + (PW'(1) <<< 45)) >>> 46;
        if (r > PW'(e2q_pkg::OUT_MAX)) begin
            return e2q_pkg::OUT_MAX;
        end else if (r < -PW'(e2q_pkg::OUT_MAX)) begin
            return -e2q_pkg::OUT_MAX;
        end
        return r[e2q_pkg::QUAT_W-1:0];
    endfunction

    // Stage C: rounding and saturation.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_quat.quat_w <= to_q14(r_w);
            o_quat.quat_x <= to_q14(r_x);
            o_quat.quat_y <= to_q14(r_y);
            o_quat.quat_z <= to_q14(r_z);
        end
    end
endmodule

// File: src/euler_to_quaternion_core.sv
// Throughput: one transaction per cycle; the whole pipeline holds on a stall.
// Depth is the input fold register, the CORDIC stage chain and three
// multiply/round stages.
// Reset clears only the valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
// euler_to_quaternion_core
// ZYX Euler angles (Q2.13) to unit quaternion (Q1.14), fully pipelined.
// ----------------------------------------------------------------------------
module euler_to_quaternion_core #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    e2q_angle_if.sink         i_angles,
    e2q_quat_if.source        o_quat
);
    localparam int NS  = (CORDIC_STAGES < e2q_pkg::ATAN_ENTRIES) ?
                         CORDIC_STAGES : e2q_pkg::ATAN_ENTRIES;
    localparam int LAT = NS + 4;

    logic [LAT-1:0] r_vld;
    logic           w_en;

    // Pipeline advances unless the output holds an untaken result.
    assign w_en           = !(r_vld[LAT-1] && !o_quat.ready);
    assign i_angles.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_angles.valid};
        end
    end

    logic signed [e2q_pkg::CW-1:0] w_cr, w_sr, w_cp, w_sp, w_cy, w_sy;

    e2q_cordic #(.STAGES(CORDIC_STAGES)) u_roll (
        .i_clk(i_clk), .i_en(w_en), .i_angle(i_angles.data.roll_angle),
        .o_cos(w_cr), .o_sin(w_sr));
    e2q_cordic #(.STAGES(CORDIC_STAGES)) u_pitch (
        .i_clk(i_clk), .i_en(w_en), .i_angle(i_angles.data.pitch_angle),
        .o_cos(w_cp), .o_sin(w_sp));
    e2q_cordic #(.STAGES(CORDIC_STAGES)) u_yaw (
        .i_clk(i_clk), .i_en(w_en), .i_angle(i_angles.data.yaw_angle),
        .o_cos(w_cy), .o_sin(w_sy));

    e2q_combine u_comb (
        .i_clk(i_clk), .i_en(w_en),
        .i_cr(w_cr), .i_sr(w_sr), .i_cp(w_cp), .i_sp(w_sp),
        .i_cy(w_cy), .i_sy(w_sy), .o_quat(o_quat.data));

    assign o_quat.valid = r_vld[LAT-1];

    // A held result must stay put while it waits.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_quat.valid && !o_quat.ready |=> o_quat.valid && $stable(o_quat.data))
        else $error("result changed while stalled");
    // Input is refused only when the output is stalled.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_angles.ready |-> o_quat.valid && !o_quat.ready)
        else $error("input refused without stall");
    // The w output stays within the unit range.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_quat.valid |-> o_quat.data.quat_w <= e2q_pkg::OUT_MAX
                      && o_quat.data.quat_w >= -e2q_pkg::OUT_MAX)
        else $error("quat_w out of range");
endmodule
